// File: design/erg_pkg.sv
package erg_pkg;

  localparam int MAX_ENTITIES = 256;
  localparam int SIG_W        = 32;
  localparam int IDX_W        = $clog2(MAX_ENTITIES);
  localparam int ID_W         = IDX_W + 1;
  localparam int STATUS_W     = 2;

  typedef enum logic [2:0] {
    ACT_REGISTER,
    ACT_UPDATE,
    ACT_UNREGISTER,
    ACT_HAS_ENTITY,
    ACT_HAS_TEMPLATE,
    ACT_READ_SIG,
    ACT_COUNT_EXACT,
    ACT_COUNT_PARTIAL
  } action_t;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_issue;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

// File: design/erg_ram.sv
module erg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/erg_ctrl.sv
module erg_ctrl
  import erg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] action,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   is_count;

  assign is_count = (action_t'(action) == ACT_COUNT_EXACT) ||
                    (action_t'(action) == ACT_COUNT_PARTIAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = is_count ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.scan_issue = 1'b0;
    cmd.load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = !rst;
        cmd.accept = in_valid && !rst;
      end
      S_SCAN: cmd.scan_issue = 1'b1;
      S_EXEC: cmd.load = !out_valid || out_ready;
      default: ;
    endcase
  end

endmodule

// File: design/erg_dp.sv
module erg_dp
  import erg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output dp_status_t          stat,
  input  logic [2:0]          action,
  input  logic [ID_W-1:0]     entity_id,
  input  logic                is_template,
  input  logic                allow_template,
  input  logic [SIG_W-1:0]    signature,
  output logic [ID_W-1:0]     result_id,
  output logic [STATUS_W-1:0] status,
  output logic                is_present,
  output logic [SIG_W-1:0]    signature_out,
  output logic [ID_W-1:0]     match_count,
  output logic [ID_W-1:0]     live_count
);

  // latched item
  action_t          act_q;
  logic [ID_W-1:0]  id_q;
  logic             tmpl_q;
  logic             allow_q;
  logic [SIG_W-1:0] sig_q;

  // table state
  logic [MAX_ENTITIES-1:0] used;
  logic [MAX_ENTITIES-1:0] tmpl;
  logic [ID_W-1:0]         allocated, allocated_next;
  logic [ID_W-1:0]         depth, depth_next;

  // scan
  logic [ID_W-1:0] scan_idx;
  logic            scan_go;
  logic            p_hit;
  logic [ID_W-1:0] acc;
  logic            sig_match;

  // memories
  logic             sig_we, sig_re;
  logic [IDX_W-1:0] sig_waddr, sig_raddr;
  logic [SIG_W-1:0] sig_rdata;
  logic             stk_we;
  logic [ID_W-1:0]  stk_rdata;

  // execute
  logic [ID_W-1:0]     id_m1_q, in_id_m1, depth_m1, rid_m1;
  logic [IDX_W-1:0]    li_idx;
  logic                live;
  logic                flag_we, flag_used, flag_tmpl;
  logic [IDX_W-1:0]    flag_idx;
  logic [ID_W-1:0]     res_id, res_count;
  logic [STATUS_W-1:0] res_status;
  logic                res_present;
  logic [SIG_W-1:0]    res_sig;

  assign in_id_m1 = entity_id - ID_W'(1);
  assign id_m1_q  = id_q - ID_W'(1);
  assign depth_m1 = depth - ID_W'(1);
  assign rid_m1   = stk_rdata - ID_W'(1);
  assign li_idx   = id_m1_q[IDX_W-1:0];
  assign live     = (id_q != '0) && (id_m1_q < allocated) && used[li_idx];

  assign stat.scan_done = (scan_idx == allocated);
  assign scan_go        = cmd.scan_issue && !stat.scan_done;

  assign sig_re    = cmd.accept || scan_go;
  assign sig_raddr = cmd.accept ? in_id_m1[IDX_W-1:0] : scan_idx[IDX_W-1:0];
  assign sig_match = (act_q == ACT_COUNT_EXACT) ? (sig_rdata == sig_q)
                                                : ((sig_rdata & sig_q) == sig_q);

  erg_ram #(.WIDTH(SIG_W), .DEPTH(MAX_ENTITIES)) u_sig_ram (
    .clk  (clk),
    .we   (sig_we),
    .waddr(sig_waddr),
    .wdata(sig_q),
    .re   (sig_re),
    .raddr(sig_raddr),
    .rdata(sig_rdata)
  );

  erg_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTITIES)) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(depth[IDX_W-1:0]),
    .wdata(id_q),
    .re   (cmd.accept),
    .raddr(depth_m1[IDX_W-1:0]),
    .rdata(stk_rdata)
  );

  always_comb begin
    allocated_next = allocated;
    depth_next     = depth;
    res_id         = '0;
    res_status     = ST_OK;
    res_present    = 1'b0;
    res_sig        = '0;
    res_count      = '0;
    flag_we        = 1'b0;
    flag_idx       = li_idx;
    flag_used      = 1'b0;
    flag_tmpl      = 1'b0;
    sig_we         = 1'b0;
    sig_waddr      = li_idx;
    stk_we         = 1'b0;
    unique case (act_q) inside
      ACT_REGISTER: begin
        if (depth != '0) begin
          depth_next = depth_m1;
          res_id     = stk_rdata;
          flag_idx   = rid_m1[IDX_W-1:0];
          flag_we    = 1'b1;
        end else if (allocated < ID_W'(MAX_ENTITIES)) begin
          allocated_next = allocated + ID_W'(1);
          res_id         = allocated + ID_W'(1);
          flag_idx       = allocated[IDX_W-1:0];
          flag_we        = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
        flag_used = 1'b1;
        flag_tmpl = tmpl_q;
        sig_we    = flag_we;
        sig_waddr = flag_idx;
      end
      ACT_UPDATE: begin
        if (live) sig_we = 1'b1;
        else res_status = ST_NOT_FOUND;
      end
      ACT_UNREGISTER: begin
        if (live) begin
          flag_we = 1'b1;
          if (depth < ID_W'(MAX_ENTITIES)) begin
            stk_we     = 1'b1;
            depth_next = depth + ID_W'(1);
          end
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      ACT_HAS_ENTITY:   res_present = live && (allow_q || !tmpl[li_idx]);
      ACT_HAS_TEMPLATE: res_present = live && tmpl[li_idx];
      ACT_READ_SIG: begin
        if (live) res_sig = sig_rdata;
        else res_status = ST_NOT_FOUND;
      end
      ACT_COUNT_EXACT, ACT_COUNT_PARTIAL: res_count = acc;
      default: ;
    endcase
    // table writes happen only when the result is loaded
    flag_we = flag_we && cmd.load;
    sig_we  = sig_we && cmd.load;
    stk_we  = stk_we && cmd.load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      tmpl      <= '0;
      allocated <= '0;
      depth     <= '0;
      scan_idx  <= '0;
      p_hit     <= 1'b0;
      acc       <= '0;
    end else begin
      p_hit <= scan_go && used[scan_idx[IDX_W-1:0]];
      if (cmd.accept) begin
        scan_idx <= '0;
        acc      <= '0;
      end else begin
        if (scan_go) scan_idx <= scan_idx + ID_W'(1);
        if (p_hit && sig_match) acc <= acc + ID_W'(1);
      end
      if (cmd.load) begin
        allocated <= allocated_next;
        depth     <= depth_next;
      end
      if (flag_we) begin
        used[flag_idx] <= flag_used;
        tmpl[flag_idx] <= flag_tmpl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q   <= action_t'(action);
      id_q    <= entity_id;
      tmpl_q  <= is_template;
      allow_q <= allow_template;
      sig_q   <= signature;
    end
    if (cmd.load) begin
      result_id     <= res_id;
      status        <= res_status;
      is_present    <= res_present;
      signature_out <= res_sig;
      match_count   <= res_count;
      live_count    <= allocated_next - depth_next;
    end
  end

endmodule

// File: design/entity_id_registry.sv
// Results are registered: an accepted item passes the execute state and is loaded into
//   the result register; count actions first scan the allocated records.
// A new item is taken only once the last result is loaded, so items do not overlap;
//   a count walks the signature RAM one entry per cycle and holds off input.
// Reset (rst, synchronous): clears used and template flags, allocation and
//   recycle counters and the control state; signature and recycle RAMs are not cleared.
module entity_id_registry
  import erg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input item channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          action,
  input  logic [ID_W-1:0]     entity_id,
  input  logic                is_template,
  input  logic                allow_template,
  input  logic [SIG_W-1:0]    signature,
  // result item channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ID_W-1:0]     result_id,
  output logic [STATUS_W-1:0] status,
  output logic                is_present,
  output logic [SIG_W-1:0]    signature_out,
  output logic [ID_W-1:0]     match_count,
  output logic [ID_W-1:0]     live_count
);

  // The controller sequences accept, optional table scan and result load;
  // the datapath owns the table flags, counters, RAMs and the result register.
  cmd_t       cmd;
  dp_status_t stat;

  erg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The result register holds a finished item while the next one is
  // accepted and worked on; load waits only when it is still full.
  erg_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .entity_id     (entity_id),
    .is_template   (is_template),
    .allow_template(allow_template),
    .signature     (signature),
    .result_id     (result_id),
    .status        (status),
    .is_present    (is_present),
    .signature_out (signature_out),
    .match_count   (match_count),
    .live_count    (live_count)
  );

endmodule

// File: design/erg_chk.sv
module erg_chk
  import erg_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ID_W-1:0]     result_id,
  input logic [STATUS_W-1:0] status,
  input logic [ID_W-1:0]     live_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> live_count <= ID_W'(MAX_ENTITIES))
    else $error("live count beyond table size");

  a_id_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_id != '0 |-> status == ST_OK)
    else $error("identifier given with non-ok status");

endmodule

bind entity_id_registry erg_chk u_erg_chk (.*);
